@@ sv/edf_ready_queue_defines.svh @@
// Assertion macros for the EDF ready queue.
// Used by the top level; needs clk and arst_n in scope.
`ifndef EDF_READY_QUEUE_DEFINES_SVH
`define EDF_READY_QUEUE_DEFINES_SVH

// check outside reset; disabled while arst_n is low
`define EDFQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check at every edge, reset included
`define EDFQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/edfq_pkg.sv @@
// Shared constants, codes and types for the EDF ready queue.
// No dependencies.
`default_nettype none
package edfq_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_RELEASE  = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [7:0]  number;
		logic [15:0] run_time;
		logic [31:0] deadline;
	} task_t;

	typedef struct packed {
		logic       insert;
		logic       remove;
		logic       load;
		logic [1:0] code;
	} cmd_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic [CNT_W-1:0] count;
	} dstat_t;
endpackage
`default_nettype wire

@@ sv/edfq_ctrl.sv @@
// Handshake controller for the EDF ready queue.
// Depends on edfq_pkg; drives commands to edfq_dpath.
`default_nettype none
module edfq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic           operation,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire edfq_pkg::dstat_t dstat,
	output edfq_pkg::cmd_t      cmd
);
	import edfq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_HOLD = 1'b1;

	logic state_q;
	logic accept;

	assign out_valid = (state_q == ST_HOLD);
	assign in_stall  = (state_q == ST_HOLD) && out_stall;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		cmd.load   = accept;
		cmd.insert = accept && (operation == OP_RELEASE) && !dstat.full;
		cmd.remove = accept && (operation == OP_DISPATCH) && !dstat.empty;
		if (operation == OP_RELEASE) begin
			cmd.code = dstat.full ? STAT_FULL : STAT_OK;
		end else begin
			cmd.code = dstat.empty ? STAT_EMPTY : STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (!out_stall && !accept) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ sv/edfq_dpath.sv @@
// Sorted cell chain and result register for the EDF ready queue.
// Depends on edfq_pkg; commanded by edfq_ctrl.
`default_nettype none
module edfq_dpath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire edfq_pkg::cmd_t  cmd,
	input  wire edfq_pkg::task_t new_task,
	output edfq_pkg::dstat_t     dstat,
	output logic [1:0]           status,
	output edfq_pkg::task_t      res_task,
	output logic [4:0]           occupancy
);
	import edfq_pkg::*;

	task_t            cells_q [QUEUE_DEPTH];
	task_t            from_below [QUEUE_DEPTH];
	task_t            from_above [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] after;
	logic [QUEUE_DEPTH-1:0] after_prev;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;
	logic [CNT_W+4:0] cnt_wide;
	logic [1:0]       status_q;
	task_t            res_q;
	logic [4:0]       occ_q;

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			assign after[gi] = (CNT_W'(gi) >= cnt_q) ||
				(cells_q[gi].deadline > new_task.deadline);
			if (gi == 0) begin : g_first
				assign from_below[gi] = new_task;
				assign after_prev[gi] = 1'b0;
			end else begin : g_rest
				assign from_below[gi] = cells_q[gi-1];
				assign after_prev[gi] = after[gi-1];
			end
			if (gi == QUEUE_DEPTH - 1) begin : g_last
				assign from_above[gi] = cells_q[gi];
			end else begin : g_mid
				assign from_above[gi] = cells_q[gi+1];
			end

			always_ff @(posedge clk) begin
				if (cmd.insert) begin
					if (after[gi] && !after_prev[gi]) begin
						cells_q[gi] <= new_task;
					end else if (after[gi]) begin
						cells_q[gi] <= from_below[gi];
					end
				end else if (cmd.remove) begin
					cells_q[gi] <= from_above[gi];
				end
			end
		end
	endgenerate

	always_comb begin
		cnt_next = cnt_q;
		if (cmd.insert) cnt_next = cnt_q + CNT_W'(1);
		else if (cmd.remove) cnt_next = cnt_q - CNT_W'(1);
	end

	assign cnt_wide    = {5'b0, cnt_next};
	assign dstat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign dstat.empty = (cnt_q == '0);
	assign dstat.count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= cmd.code;
			res_q    <= cmd.remove ? cells_q[0] : '0;
			occ_q    <= cnt_wide[4:0];
		end
	end

	assign status    = status_q;
	assign res_task  = res_q;
	assign occupancy = occ_q;
endmodule
`default_nettype wire

@@ sv/edf_ready_queue.sv @@
// EDF ready queue, top level: controller plus sorted cell datapath.
// Depends on edfq_pkg, edfq_ctrl, edfq_dpath and edf_ready_queue_defines.svh.
//
// Use: each input transfer is a release (operation 0: insert a task by
// deadline, ties first-in first-out) or a dispatch (operation 1: remove
// the earliest-deadline task). Every input transfer yields exactly one
// output transfer with status, the dispatched task (zeros otherwise) and
// the occupancy after the item.
// Latency: the result is valid the cycle after the input transfer.
// Throughput: one item per cycle while out_stall is low; the cell chain compares all held
// deadlines in parallel and shifts them.
// The single output register holds one result; while it is held and
// out_stall is high, in_stall rises and no new item is taken. A result
// taken in the same cycle as a new input frees the register for it.
// Reset empties the queue and drops any held result; stored cells are
// not cleared.
`default_nettype none
`include "edf_ready_queue_defines.svh"
module edf_ready_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic        task_kind,
	input  wire logic [7:0]  task_number,
	input  wire logic [15:0] run_time,
	input  wire logic [31:0] deadline,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic             out_kind,
	output logic [7:0]       out_number,
	output logic [15:0]      out_run_time,
	output logic [31:0]      out_deadline,
	output logic [4:0]       occupancy
);
	import edfq_pkg::*;

	cmd_t   cmd;
	dstat_t dstat;
	task_t  new_task;
	task_t  res_task;
	logic   accept;

	assign new_task.kind     = task_kind;
	assign new_task.number   = task_number;
	assign new_task.run_time = run_time;
	assign new_task.deadline = deadline;
	assign accept            = in_valid && !in_stall;

	edfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dstat     (dstat),
		.cmd       (cmd)
	);

	edfq_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.new_task  (new_task),
		.dstat     (dstat),
		.status    (status),
		.res_task  (res_task),
		.occupancy (occupancy)
	);

	assign out_kind     = res_task.kind;
	assign out_number   = res_task.number;
	assign out_run_time = res_task.run_time;
	assign out_deadline = res_task.deadline;

	`EDFQ_ASSERT_ALWAYS(a_count_bound, !arst_n || dstat.count <= CNT_W'(QUEUE_DEPTH), "count above depth")
	`EDFQ_ASSERT(a_insert_grows, accept && operation == OP_RELEASE && !dstat.full |=> dstat.count == $past(dstat.count) + CNT_W'(1), "release did not grow queue")
	`EDFQ_ASSERT(a_empty_flag, accept && operation == OP_DISPATCH && dstat.empty |=> out_valid && status == STAT_EMPTY, "empty dispatch not flagged")
	`EDFQ_ASSERT(a_nonok_zero, out_valid && status != STAT_OK |-> res_task == '0, "failed item carries a task")
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for edf_ready_queue: release and dispatch transfers with random gaps and
// output stalls, each result checked against a sorted ready list kept here.
// Depends on edfq_pkg and edf_ready_queue.
module tb_top;
	import edfq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0] status;
		task_t      head;
		logic [4:0] occupancy;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = OP_RELEASE;
	logic        task_kind = 1'b0;
	logic [7:0]  task_number = '0;
	logic [15:0] run_time = '0;
	logic [31:0] deadline = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        out_kind;
	logic [7:0]  out_number;
	logic [15:0] out_run_time;
	logic [31:0] out_deadline;
	logic [4:0]  occupancy;

	task_t         ready_list[$];
	queue_result_t expected_results[$];
	int            error_count = 0;
	int            cycle_count = 0;
	int            stall_left = 0;
	bit            sender_gaps = 1'b0;
	bit            receiver_stalls = 1'b0;

	edf_ready_queue uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.task_kind    (task_kind),
		.task_number  (task_number),
		.run_time     (run_time),
		.deadline     (deadline),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_kind     (out_kind),
		.out_number   (out_number),
		.out_run_time (out_run_time),
		.out_deadline (out_deadline),
		.occupancy    (occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (receiver_stalls && $urandom_range(0, 6) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 10);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// insert before the first strictly later deadline, pop the head on dispatch
	function automatic queue_result_t apply_item(logic op, task_t item);
		queue_result_t res;
		int            pos;
		res = '0;
		if (op == OP_RELEASE) begin
			if (ready_list.size() >= QUEUE_DEPTH) begin
				res.status = STAT_FULL;
			end else begin
				pos = ready_list.size();
				for (int i = 0; i < ready_list.size(); i++) begin
					if (ready_list[i].deadline > item.deadline) begin
						pos = i;
						break;
					end
				end
				ready_list.insert(pos, item);
				res.status = STAT_OK;
			end
		end else if (ready_list.size() == 0) begin
			res.status = STAT_EMPTY;
		end else begin
			res.head = ready_list.pop_front();
			res.status = STAT_OK;
		end
		res.occupancy = 5'(ready_list.size());
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		queue_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: status expected none actual %0h", $time, status);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("out_kind", 32'(want.head.kind), 32'(out_kind));
				check_field("out_number", 32'(want.head.number), 32'(out_number));
				check_field("out_run_time", 32'(want.head.run_time), 32'(out_run_time));
				check_field("out_deadline", want.head.deadline, out_deadline);
				check_field("occupancy", 32'(want.occupancy), 32'(occupancy));
			end
		end
	end

	function automatic task_t random_task();
		task_t t;
		t.kind = 1'($urandom_range(0, 1));
		t.number = 8'($urandom_range(0, 255));
		t.run_time = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 3))
			0: t.deadline = $urandom;
			1: t.deadline = 32'hFFFF_FFF0 + $urandom_range(0, 15);
			default: t.deadline = $urandom_range(0, 31);
		endcase
		return t;
	endfunction

	task automatic send_item(logic op, task_t item);
		int gap;
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		task_kind <= item.kind;
		task_number <= item.number;
		run_time <= item.run_time;
		deadline <= item.deadline;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_results.push_back(apply_item(op, item));
	endtask

	task automatic release_task(logic kind, logic [7:0] number, logic [15:0] ticks,
			logic [31:0] due);
		send_item(OP_RELEASE, {kind, number, ticks, due});
	endtask

	// payload of a dispatch is ignored, so fill it with noise
	task automatic dispatch_task();
		send_item(OP_DISPATCH, random_task());
	endtask

	task automatic test_empty_dispatch();
		dispatch_task();
		dispatch_task();
	endtask

	task automatic test_field_extremes();
		release_task(1'b1, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
		release_task(1'b0, 8'h55, 16'h5555, 32'h5555_5555);
		release_task(1'b1, 8'hAA, 16'hAAAA, 32'hAAAA_AAAA);
		release_task(1'b0, 8'h00, 16'h0000, 32'h0000_0000);
		repeat (4) dispatch_task();
		dispatch_task();
	endtask

	task automatic test_equal_deadlines();
		receiver_stalls = 1'b1;
		release_task(1'b0, 8'd1, 16'd10, 32'd100);
		release_task(1'b1, 8'd2, 16'd20, 32'd100);
		release_task(1'b0, 8'd3, 16'd30, 32'd101);
		release_task(1'b1, 8'd4, 16'd40, 32'd100);
		release_task(1'b0, 8'd5, 16'd50, 32'd99);
		release_task(1'b1, 8'd6, 16'd60, 32'd100);
		repeat (6) dispatch_task();
	endtask

	task automatic test_full_queue();
		sender_gaps = 1'b1;
		repeat (QUEUE_DEPTH) send_item(OP_RELEASE, random_task());
		repeat (2) send_item(OP_RELEASE, random_task());
		repeat (QUEUE_DEPTH + 1) dispatch_task();
	endtask

	task automatic test_random_traffic(int count);
		int sent;
		int seg;
		int release_pct;
		sent = 0;
		while (sent < count) begin
			sender_gaps = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 2))
				0: release_pct = 25;
				1: release_pct = 50;
				default: release_pct = 80;
			endcase
			seg = $urandom_range(10, 50);
			repeat (seg) begin
				if ($urandom_range(1, 100) <= release_pct)
					send_item(OP_RELEASE, random_task());
				else
					dispatch_task();
			end
			sent += seg;
		end
	endtask

	// hold the input until every pending transfer has come out
	task automatic test_pause_until_drained();
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		repeat (8) send_item(OP_RELEASE, random_task());
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (9) dispatch_task();
	endtask

	task automatic test_streaming();
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		repeat (60) begin
			if ($urandom_range(0, 1) == 0)
				send_item(OP_RELEASE, random_task());
			else
				dispatch_task();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_dispatch();
		test_field_extremes();
		test_equal_deadlines();
		test_full_queue();
		test_random_traffic(160);
		test_pause_until_drained();
		test_random_traffic(130);
		test_streaming();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+sv
sv/edfq_pkg.sv
sv/edfq_ctrl.sv
sv/edfq_dpath.sv
sv/edf_ready_queue.sv
test/tb_top.sv
